// ===== src/lti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_pkg
// Shared types and constants of the 3d lut tetrahedral interpolation unit.
// ----------------------------------------------------------------------------
package lti_pkg;

	// fixed field widths
	localparam int SIZE_W   = 5;
	localparam int INDEX_W  = 13;
	localparam int RECIP_W  = 24;
	localparam int FRAC_W   = 16;
	localparam int WEIGHT_W = 17;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;
	localparam int FRAC_ONE = 65536;

	// command codes
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	// register indexes
	typedef enum logic [2:0] {
		REG_SIZE  = 3'd0,
		REG_LOW_R = 3'd1,
		REG_LOW_G = 3'd2,
		REG_LOW_B = 3'd3,
		REG_RCP_R = 3'd4,
		REG_RCP_G = 3'd5,
		REG_RCP_B = 3'd6
	} reg_idx_t;

	// per stage load enables
	typedef struct packed {
		logic s9;
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} stage_en_t;

endpackage

// ===== src/lut3d_tetrahedral_interp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lut3d_tetrahedral_interp_unit
// 3d lut color transform with tetrahedral interpolation, nine stage pipeline.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_stall is low, lattice writes and pixels
// alike, and returns one word per pixel; lattice writes return nothing.
// Stages: offset, span multiply, clamp, cell multiply, tetrahedron pick, vertex
// address, lattice read, vertex multiply, sum and saturate. The lattice store
// is held twice, each copy with two read ports, so the four vertex reads of a
// pixel happen at once; writes land at the read stage, so they keep their order
// with pixels. Every stage moves as soon as the stage after it is free, so a
// word is still taken while a result waits, as long as the pipe has a bubble.
// The user must write configuration over the register port while idle; it is
// unchecked; the lattice holds no reset value and must be loaded before use.
module lut3d_tetrahedral_interp_unit #(
	parameter int MAX_LATTICE  = 17,
	parameter int CHANNEL_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lti_pkg::PADDR_W-1:0]           paddr,
	input  logic [lti_pkg::PDATA_W-1:0]           pwdata,
	output logic [lti_pkg::PDATA_W-1:0]           prdata,
	output logic                                  pready,
	// request channel
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  logic                                  command,
	input  logic [lti_pkg::INDEX_W-1:0]           entry_index,
	input  logic signed [CHANNEL_BITS-1:0]        entry_red,
	input  logic signed [CHANNEL_BITS-1:0]        entry_green,
	input  logic signed [CHANNEL_BITS-1:0]        entry_blue,
	input  logic signed [CHANNEL_BITS-1:0]        pixel_red,
	input  logic signed [CHANNEL_BITS-1:0]        pixel_green,
	input  logic signed [CHANNEL_BITS-1:0]        pixel_blue,
	// result channel
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [CHANNEL_BITS-1:0]        out_red,
	output logic signed [CHANNEL_BITS-1:0]        out_green,
	output logic signed [CHANNEL_BITS-1:0]        out_blue
);
	import lti_pkg::*;

	localparam int DEPTH  = MAX_LATTICE * MAX_LATTICE * MAX_LATTICE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WORD_W = 3 * CHANNEL_BITS;

	typedef struct packed {
		logic               cmd;
		logic [INDEX_W-1:0] idx;
		logic [WORD_W-1:0]  data;
	} wr_word_t;

	// configuration registers
	logic [SIZE_W-1:0]              size_q;
	logic signed [CHANNEL_BITS-1:0] low_r_q;
	logic signed [CHANNEL_BITS-1:0] low_g_q;
	logic signed [CHANNEL_BITS-1:0] low_b_q;
	logic [RECIP_W-1:0]             rcp_r_q;
	logic [RECIP_W-1:0]             rcp_g_q;
	logic [RECIP_W-1:0]             rcp_b_q;

	logic [SIZE_W-1:0] eff_size;
	logic [SIZE_W-1:0] eff_m1;
	logic              cfg_wr;

	stage_en_t  en;
	logic [9:1] stage_vld_q;

	wr_word_t wr_s1, wr_s2, wr_s3, wr_s4, wr_s5, wr_s6;
	logic     cmd_s7;
	logic [3:0][WEIGHT_W-1:0] w_s7;

	logic [2:0][SIZE_W-1:0]   ax_lo;
	logic [2:0][SIZE_W-1:0]   ax_hi;
	logic [2:0][FRAC_W-1:0]   ax_fr;
	logic [3:0][ADDR_W-1:0]   vaddr;
	logic [3:0][WEIGHT_W-1:0] vweight;
	logic [3:0][WORD_W-1:0]   vdata;
	logic [3:0][CHANNEL_BITS-1:0] v_r, v_g, v_b;
	logic                     mem_we;

	// register writes and reads
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_W'(17);
			low_r_q <= '0;
			low_g_q <= '0;
			low_b_q <= '0;
			rcp_r_q <= RECIP_W'(FRAC_ONE);
			rcp_g_q <= RECIP_W'(FRAC_ONE);
			rcp_b_q <= RECIP_W'(FRAC_ONE);
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SIZE:  size_q  <= pwdata[SIZE_W-1:0];
				REG_LOW_R: low_r_q <= pwdata[CHANNEL_BITS-1:0];
				REG_LOW_G: low_g_q <= pwdata[CHANNEL_BITS-1:0];
				REG_LOW_B: low_b_q <= pwdata[CHANNEL_BITS-1:0];
				REG_RCP_R: rcp_r_q <= pwdata[RECIP_W-1:0];
				REG_RCP_G: rcp_g_q <= pwdata[RECIP_W-1:0];
				REG_RCP_B: rcp_b_q <= pwdata[RECIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_SIZE:  prdata = PDATA_W'(size_q);
			REG_LOW_R: prdata = PDATA_W'(low_r_q);
			REG_LOW_G: prdata = PDATA_W'(low_g_q);
			REG_LOW_B: prdata = PDATA_W'(low_b_q);
			REG_RCP_R: prdata = PDATA_W'(rcp_r_q);
			REG_RCP_G: prdata = PDATA_W'(rcp_g_q);
			REG_RCP_B: prdata = PDATA_W'(rcp_b_q);
			default:   prdata = '0;
		endcase
	end

	// lattice size in use, clamped to [2, max]
	always_comb begin
		if (size_q < SIZE_W'(2)) begin
			eff_size = SIZE_W'(2);
		end else if (int'(size_q) > MAX_LATTICE) begin
			eff_size = SIZE_W'(MAX_LATTICE);
		end else begin
			eff_size = size_q;
		end
		eff_m1 = eff_size - 1'b1;
	end

	// stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		en.s9 = !stage_vld_q[9] || !res_stall;
		en.s8 = !stage_vld_q[8] || en.s9;
		en.s7 = !stage_vld_q[7] || en.s8;
		en.s6 = !stage_vld_q[6] || en.s7;
		en.s5 = !stage_vld_q[5] || en.s6;
		en.s4 = !stage_vld_q[4] || en.s5;
		en.s3 = !stage_vld_q[3] || en.s4;
		en.s2 = !stage_vld_q[2] || en.s3;
		en.s1 = !stage_vld_q[1] || en.s2;
	end

	assign req_stall = !en.s1;
	assign res_valid = stage_vld_q[9];

	// valid bits travel with the words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en.s1) stage_vld_q[1] <= req_valid;
			if (en.s2) stage_vld_q[2] <= stage_vld_q[1];
			if (en.s3) stage_vld_q[3] <= stage_vld_q[2];
			if (en.s4) stage_vld_q[4] <= stage_vld_q[3];
			if (en.s5) stage_vld_q[5] <= stage_vld_q[4];
			if (en.s6) stage_vld_q[6] <= stage_vld_q[5];
			if (en.s7) stage_vld_q[7] <= stage_vld_q[6];
			if (en.s8) stage_vld_q[8] <= stage_vld_q[7] && (cmd_s7 == CMD_PIXEL);
			if (en.s9) stage_vld_q[9] <= stage_vld_q[8];
		end
	end

	// command and lattice entry carried down to the store stage
	always_ff @(posedge clk) begin
		if (en.s1) wr_s1 <= '{cmd: command, idx: entry_index,
			data: {entry_blue, entry_green, entry_red}};
		if (en.s2) wr_s2 <= wr_s1;
		if (en.s3) wr_s3 <= wr_s2;
		if (en.s4) wr_s4 <= wr_s3;
		if (en.s5) wr_s5 <= wr_s4;
		if (en.s6) wr_s6 <= wr_s5;
		if (en.s7) begin
			cmd_s7 <= wr_s6.cmd;
			w_s7   <= vweight;
		end
	end

	// per channel coordinate mapping
	lti_axis #(.CHANNEL_BITS(CHANNEL_BITS)) u_axis_r (
		.clk(clk), .en(en), .pixel(pixel_red), .low(low_r_q), .recip(rcp_r_q),
		.size(eff_size), .size_m1(eff_m1),
		.lo(ax_lo[0]), .hi(ax_hi[0]), .fr(ax_fr[0])
	);
	lti_axis #(.CHANNEL_BITS(CHANNEL_BITS)) u_axis_g (
		.clk(clk), .en(en), .pixel(pixel_green), .low(low_g_q), .recip(rcp_g_q),
		.size(eff_size), .size_m1(eff_m1),
		.lo(ax_lo[1]), .hi(ax_hi[1]), .fr(ax_fr[1])
	);
	lti_axis #(.CHANNEL_BITS(CHANNEL_BITS)) u_axis_b (
		.clk(clk), .en(en), .pixel(pixel_blue), .low(low_b_q), .recip(rcp_b_q),
		.size(eff_size), .size_m1(eff_m1),
		.lo(ax_lo[2]), .hi(ax_hi[2]), .fr(ax_fr[2])
	);

	lti_addr #(.ADDR_W(ADDR_W)) u_addr (
		.clk(clk), .en(en), .lo(ax_lo), .hi(ax_hi), .fr(ax_fr),
		.size(eff_size), .addr(vaddr), .weight(vweight)
	);

	// entry writes beyond the store are dropped
	assign mem_we = en.s7 && stage_vld_q[6] && (wr_s6.cmd == CMD_WRITE)
		&& (32'(wr_s6.idx) < 32'(DEPTH));

	lti_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WORD_W(WORD_W)) u_store (
		.clk(clk), .rd_en(en.s7), .we(mem_we), .waddr(ADDR_W'(wr_s6.idx)),
		.wdata(wr_s6.data), .raddr(vaddr), .rdata(vdata)
	);

	// split vertex words into channels
	always_comb begin
		for (int v = 0; v < 4; v++) begin
			v_r[v] = vdata[v][0 +: CHANNEL_BITS];
			v_g[v] = vdata[v][CHANNEL_BITS +: CHANNEL_BITS];
			v_b[v] = vdata[v][2*CHANNEL_BITS +: CHANNEL_BITS];
		end
	end

	lti_blend #(.CHANNEL_BITS(CHANNEL_BITS)) u_blend_r (
		.clk(clk), .en(en), .weight(w_s7), .vertex(v_r), .result(out_red)
	);
	lti_blend #(.CHANNEL_BITS(CHANNEL_BITS)) u_blend_g (
		.clk(clk), .en(en), .weight(w_s7), .vertex(v_g), .result(out_green)
	);
	lti_blend #(.CHANNEL_BITS(CHANNEL_BITS)) u_blend_b (
		.clk(clk), .en(en), .weight(w_s7), .vertex(v_b), .result(out_blue)
	);

	// a held request means a full pipe behind a waiting result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall && (&stage_vld_q)))
		else $error("request stalled with a bubble in the pipe");

	// a pixel in stage eight reaches the output next cycle when it is free
	a_pixel_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_vld_q[8] && !res_valid) |=> res_valid)
		else $error("pixel lost between last two stages");

	// clamped lattice size stays in range
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(eff_size >= SIZE_W'(2)) && (int'(eff_size) <= MAX_LATTICE))
		else $error("lattice size out of range");

endmodule

// ===== src/lti_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_axis
// One channel of lattice coordinate mapping, stages one to four: offset,
// scale by reciprocal span, clamp to unit range, scale to lattice cells.
// ----------------------------------------------------------------------------
module lti_axis #(
	parameter int CHANNEL_BITS = 20
) (
	input  logic                               clk,
	input  lti_pkg::stage_en_t                 en,
	input  logic signed [CHANNEL_BITS-1:0]     pixel,
	input  logic signed [CHANNEL_BITS-1:0]     low,
	input  logic [lti_pkg::RECIP_W-1:0]        recip,
	input  logic [lti_pkg::SIZE_W-1:0]         size,
	input  logic [lti_pkg::SIZE_W-1:0]         size_m1,
	output logic [lti_pkg::SIZE_W-1:0]         lo,
	output logic [lti_pkg::SIZE_W-1:0]         hi,
	output logic [lti_pkg::FRAC_W-1:0]         fr
);
	import lti_pkg::*;

	localparam int DIFF_W = CHANNEL_BITS + 1;
	localparam int PROD_W = DIFF_W + RECIP_W + 1;
	localparam int SH_W   = PROD_W - FRAC_W;
	localparam int POS_W  = WEIGHT_W + SIZE_W;

	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic [WEIGHT_W-1:0]      unit_s3;
	logic [SIZE_W-1:0]        lo_s4;
	logic [SIZE_W-1:0]        hi_s4;
	logic [FRAC_W-1:0]        fr_s4;

	logic [SH_W-1:0]     shifted;
	logic [WEIGHT_W-1:0] unit_next;
	logic [POS_W-1:0]    pos;
	logic [SIZE_W-1:0]   lo_next;
	logic [SIZE_W:0]     lo_inc;

	// clamp scaled value to [0, one]
	always_comb begin
		shifted = prod_s2[PROD_W-1:FRAC_W];
		if (prod_s2 < 0) begin
			unit_next = '0;
		end else if (shifted > SH_W'(FRAC_ONE)) begin
			unit_next = WEIGHT_W'(FRAC_ONE);
		end else begin
			unit_next = shifted[WEIGHT_W-1:0];
		end
	end

	// cell position, lower and upper index
	always_comb begin
		pos     = POS_W'(unit_s3) * POS_W'(size_m1);
		lo_next = pos[FRAC_W +: SIZE_W];
		lo_inc  = {1'b0, lo_next} + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_s1 <= DIFF_W'(pixel) - DIFF_W'(low);
		end
		if (en.s2) begin
			prod_s2 <= PROD_W'(diff_s1) * PROD_W'(signed'({1'b0, recip}));
		end
		if (en.s3) begin
			unit_s3 <= unit_next;
		end
		if (en.s4) begin
			lo_s4 <= lo_next;
			fr_s4 <= pos[FRAC_W-1:0];
			hi_s4 <= (lo_inc < {1'b0, size}) ? lo_inc[SIZE_W-1:0] : lo_next;
		end
	end

	assign lo = lo_s4;
	assign hi = hi_s4;
	assign fr = fr_s4;

endmodule

// ===== src/lti_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_addr
// Tetrahedron choice and vertex addressing, stages five and six: orders the
// fractions, forms the four weights and the four lattice addresses.
// ----------------------------------------------------------------------------
module lti_addr #(
	parameter int ADDR_W = 13
) (
	input  logic                                          clk,
	input  lti_pkg::stage_en_t                            en,
	input  logic [2:0][lti_pkg::SIZE_W-1:0]               lo,
	input  logic [2:0][lti_pkg::SIZE_W-1:0]               hi,
	input  logic [2:0][lti_pkg::FRAC_W-1:0]               fr,
	input  logic [lti_pkg::SIZE_W-1:0]                    size,
	output logic [3:0][ADDR_W-1:0]                        addr,
	output logic [3:0][lti_pkg::WEIGHT_W-1:0]             weight
);
	import lti_pkg::*;

	// vertex select bits: bit 0 red, bit 1 green, bit 2 blue, set means upper
	logic [2:0]                sel_a;
	logic [2:0]                sel_b;
	logic [3:0][WEIGHT_W-1:0]  w_next;
	logic [3:0][ADDR_W-1:0]    row_next;
	logic [3:0][2:0]           vsel;
	logic [WEIGHT_W-1:0]       f0;
	logic [WEIGHT_W-1:0]       f1;
	logic [WEIGHT_W-1:0]       f2;
	logic [WEIGHT_W-1:0]       one;

	logic [3:0][WEIGHT_W-1:0]  w_s5;
	logic [2:0]                sel_a_s5;
	logic [2:0]                sel_b_s5;
	logic [3:0][ADDR_W-1:0]    row_s5;
	logic [SIZE_W-1:0]         rlo_s5;
	logic [SIZE_W-1:0]         rhi_s5;
	logic [3:0][ADDR_W-1:0]    addr_s6;
	logic [3:0][WEIGHT_W-1:0]  w_s6;

	// pick the tetrahedron from the fraction order
	always_comb begin
		f0  = WEIGHT_W'(fr[0]);
		f1  = WEIGHT_W'(fr[1]);
		f2  = WEIGHT_W'(fr[2]);
		one = WEIGHT_W'(FRAC_ONE);
		if (f0 >= f1) begin
			if (f1 >= f2) begin
				sel_a  = 3'b001;
				sel_b  = 3'b011;
				w_next = {f2, f1 - f2, f0 - f1, one - f0};
			end else if (f0 >= f2) begin
				sel_a  = 3'b001;
				sel_b  = 3'b101;
				w_next = {f1, f2 - f1, f0 - f2, one - f0};
			end else begin
				sel_a  = 3'b100;
				sel_b  = 3'b101;
				w_next = {f1, f0 - f1, f2 - f0, one - f2};
			end
		end else begin
			if (f2 >= f1) begin
				sel_a  = 3'b100;
				sel_b  = 3'b110;
				w_next = {f0, f1 - f0, f2 - f1, one - f2};
			end else if (f2 >= f0) begin
				sel_a  = 3'b010;
				sel_b  = 3'b110;
				w_next = {f0, f2 - f0, f1 - f2, one - f1};
			end else begin
				sel_a  = 3'b010;
				sel_b  = 3'b011;
				w_next = {f2, f0 - f2, f1 - f0, one - f1};
			end
		end
	end

	// row term blue*size+green for each blue/green choice
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			row_next[k] = ADDR_W'(k[1] ? hi[2] : lo[2]) * ADDR_W'(size)
				+ ADDR_W'(k[0] ? hi[1] : lo[1]);
		end
	end

	assign vsel = {3'b111, sel_b_s5, sel_a_s5, 3'b000};

	always_ff @(posedge clk) begin
		if (en.s5) begin
			w_s5     <= w_next;
			sel_a_s5 <= sel_a;
			sel_b_s5 <= sel_b;
			row_s5   <= row_next;
			rlo_s5   <= lo[0];
			rhi_s5   <= hi[0];
		end
		if (en.s6) begin
			w_s6 <= w_s5;
			for (int v = 0; v < 4; v++) begin
				addr_s6[v] <= row_s5[vsel[v][2:1]] * ADDR_W'(size)
					+ ADDR_W'(vsel[v][0] ? rhi_s5 : rlo_s5);
			end
		end
	end

	assign addr   = addr_s6;
	assign weight = w_s6;

endmodule

// ===== src/lti_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_store
// Lattice store: two identical copies, each with one write and two read
// ports, give four vertex reads a cycle while rd_en is high; read data is registered.
// ----------------------------------------------------------------------------
module lti_store #(
	parameter int DEPTH  = 4913,
	parameter int ADDR_W = 13,
	parameter int WORD_W = 60
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic                          we,
	input  logic [ADDR_W-1:0]             waddr,
	input  logic [WORD_W-1:0]             wdata,
	input  logic [3:0][ADDR_W-1:0]        raddr,
	output logic [3:0][WORD_W-1:0]        rdata
);

	logic [WORD_W-1:0] mem_a [DEPTH];
	logic [WORD_W-1:0] mem_b [DEPTH];
	logic [3:0][WORD_W-1:0] rdata_s7;

	// copy a serves vertices zero and a, copy b serves b and one
	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s7[0] <= mem_a[raddr[0]];
			rdata_s7[1] <= mem_a[raddr[1]];
			rdata_s7[2] <= mem_b[raddr[2]];
			rdata_s7[3] <= mem_b[raddr[3]];
		end
	end

	assign rdata = rdata_s7;

endmodule

// ===== src/lti_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lti_blend
// One output channel, stages eight and nine: weight the four vertices, sum,
// round half up and saturate.
// ----------------------------------------------------------------------------
module lti_blend #(
	parameter int CHANNEL_BITS = 20
) (
	input  logic                                   clk,
	input  lti_pkg::stage_en_t                     en,
	input  logic [3:0][lti_pkg::WEIGHT_W-1:0]      weight,
	input  logic [3:0][CHANNEL_BITS-1:0]           vertex,
	output logic signed [CHANNEL_BITS-1:0]         result
);
	import lti_pkg::*;

	localparam int PROD_W = CHANNEL_BITS + WEIGHT_W + 1;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Q_W    = ACC_W - FRAC_W;

	logic signed [3:0][PROD_W-1:0] prod_s8;
	logic signed [CHANNEL_BITS-1:0] result_s9;

	logic signed [ACC_W-1:0] acc;
	logic signed [Q_W-1:0]   q;
	logic signed [Q_W-1:0]   q_hi;
	logic signed [Q_W-1:0]   q_lo;

	// sum, round and saturate; each product is sign extended
	always_comb begin
		acc = ACC_W'(signed'(prod_s8[0])) + ACC_W'(signed'(prod_s8[1]))
			+ ACC_W'(signed'(prod_s8[2])) + ACC_W'(signed'(prod_s8[3]))
			+ ACC_W'(1 << (FRAC_W - 1));
		q    = acc[ACC_W-1:FRAC_W];
		q_hi = Q_W'({1'b0, {(CHANNEL_BITS-1){1'b1}}});
		q_lo = -q_hi - Q_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en.s8) begin
			for (int k = 0; k < 4; k++) begin
				prod_s8[k] <= PROD_W'(signed'({1'b0, weight[k]}))
					* PROD_W'(signed'(vertex[k]));
			end
		end
		if (en.s9) begin
			if (q > q_hi) begin
				result_s9 <= q_hi[CHANNEL_BITS-1:0];
			end else if (q < q_lo) begin
				result_s9 <= q_lo[CHANNEL_BITS-1:0];
			end else begin
				result_s9 <= q[CHANNEL_BITS-1:0];
			end
		end
	end

	assign result = result_s9;

endmodule
